/* design/dcm_pkg.sv */
// Package: shared types, constants, DES tables and permutation functions.
`timescale 1ns / 1ps
`default_nettype none
package dcm_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_MAC_MODE   = 3'd0;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd1;
    localparam logic [2:0] REG_KEY_FIRST  = 3'd2;
    localparam logic [2:0] REG_KEY_SECOND = 3'd3;
    localparam logic [2:0] REG_KEY_THIRD  = 3'd4;

    // MAC modes
    localparam logic [2:0] MODE_X99      = 3'd0;
    localparam logic [2:0] MODE_ISO_ALG3 = 3'd1;
    localparam logic [2:0] MODE_X919     = 3'd2;
    localparam logic [2:0] MODE_ISO16609 = 3'd3;
    localparam logic [2:0] MODE_AUTO     = 3'd4;

    // Key lengths
    localparam logic [1:0] KLEN_8  = 2'd0;
    localparam logic [1:0] KLEN_16 = 2'd1;
    localparam logic [1:0] KLEN_24 = 2'd2;

    localparam int ADDR_W = 6;

    typedef struct packed {
        logic [2:0]  mac_mode;
        logic [1:0]  key_length;
        logic [63:0] key_first;
        logic [63:0] key_second;
        logic [63:0] key_third;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic dec;
    } t_des_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_OUT
    } t_state;

    localparam logic [6:0] C_IP [64] = '{
        7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,
        7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
        7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,
        7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,
        7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
        7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,
        7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};

    localparam logic [6:0] C_FP [64] = '{
        7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,
        7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
        7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,
        7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
        7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,
        7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
        7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,
        7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};

    localparam logic [5:0] C_E [48] = '{
        6'd32,6'd1,6'd2,6'd3,6'd4,6'd5,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,
        6'd8,6'd9,6'd10,6'd11,6'd12,6'd13,6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,
        6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,
        6'd24,6'd25,6'd26,6'd27,6'd28,6'd29,6'd28,6'd29,6'd30,6'd31,6'd32,6'd1};

    localparam logic [5:0] C_P [32] = '{
        6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,
        6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
        6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,
        6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25};

    localparam logic [6:0] C_PC1 [56] = '{
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,
        7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,
        7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
        7'd60,7'd52,7'd44,7'd36,7'd63,7'd55,7'd47,7'd39,
        7'd31,7'd23,7'd15,7'd7,7'd62,7'd54,7'd46,7'd38,
        7'd30,7'd22,7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,
        7'd29,7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};

    localparam logic [5:0] C_PC2 [48] = '{
        6'd14,6'd17,6'd11,6'd24,6'd1,6'd5,6'd3,6'd28,
        6'd15,6'd6,6'd21,6'd10,6'd23,6'd19,6'd12,6'd4,
        6'd26,6'd8,6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,
        6'd41,6'd52,6'd31,6'd37,6'd47,6'd55,6'd30,6'd40,
        6'd51,6'd45,6'd33,6'd48,6'd44,6'd49,6'd39,6'd56,
        6'd34,6'd53,6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};

    // Shift by two in every round but rounds 1, 2, 9 and 16
    localparam logic C_ROT2 [16] = '{
        1'b0,1'b0,1'b1,1'b1,1'b1,1'b1,1'b1,1'b1,
        1'b0,1'b1,1'b1,1'b1,1'b1,1'b1,1'b1,1'b0};

    localparam logic [3:0] C_SBOX [512] = '{
        4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13,
        4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9,
        4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12,
        4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14,
        4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3,
        4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13,
        4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12,
        4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11};

    // Table positions count from 1 at the MSB of the source word
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(C_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(C_FP[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(C_PC1[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        r = '0;
        for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(C_PC2[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_e(input logic [31:0] v);
        logic [47:0] r;
        r = '0;
        for (int i = 0; i < 48; i++) r[47-i] = v[32 - int'(C_E[i])];
        return r;
    endfunction

    function automatic logic [31:0] perm_p(input logic [31:0] v);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) r[31-i] = v[32 - int'(C_P[i])];
        return r;
    endfunction

    // Eight S-box lookups, each on its own six bits
    function automatic logic [31:0] sbox_all(input logic [47:0] t);
        logic [31:0] r;
        logic [5:0]  six;
        r = '0;
        for (int j = 0; j < 8; j++) begin
            six = t[47-6*j -: 6];
            r[31-4*j -: 4] = C_SBOX[j*64 + int'({six[5], six[0], six[4:1]})];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/dcm_if.sv */
// Interfaces: message block channel and MAC result channel.
`timescale 1ns / 1ps
`default_nettype none
interface dcm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_block;
    logic [3:0]  byte_count;
    logic        last_block;

    modport source (output valid, output data_block, output byte_count,
                    output last_block, input ready);
    modport sink (input valid, input data_block, input byte_count,
                  input last_block, output ready);
endinterface

interface dcm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] mac_value;
    logic        key_error;

    modport source (output valid, output mac_value, output key_error, input ready);
    modport sink (input valid, input mac_value, input key_error, output ready);
endinterface
`default_nettype wire

/* design/dcm_cfg_regs.sv */
// Configuration register bank behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module dcm_cfg_regs
    import dcm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [63:0]       i_pwdata,
    output logic [63:0]            o_prdata,
    output logic                   o_pready,
    output t_cfg                   o_cfg
);
    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign reg_idx  = i_paddr[ADDR_W-1:3];
    assign o_cfg    = r_cfg;

    // Write the addressed register at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAC_MODE:   r_cfg.mac_mode   <= i_pwdata[2:0];
                REG_KEY_LENGTH: r_cfg.key_length <= i_pwdata[1:0];
                REG_KEY_FIRST:  r_cfg.key_first  <= i_pwdata;
                REG_KEY_SECOND: r_cfg.key_second <= i_pwdata;
                REG_KEY_THIRD:  r_cfg.key_third  <= i_pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_MAC_MODE:   o_prdata = {61'd0, r_cfg.mac_mode};
            REG_KEY_LENGTH: o_prdata = {62'd0, r_cfg.key_length};
            REG_KEY_FIRST:  o_prdata = r_cfg.key_first;
            REG_KEY_SECOND: o_prdata = r_cfg.key_second;
            REG_KEY_THIRD:  o_prdata = r_cfg.key_third;
            default:        o_prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

/* design/dcm_des_unit.sv */
// Iterative DES unit: one Feistel round and one key schedule step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dcm_des_unit
    import dcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_des_ctl    i_ctl,
    input  wire logic [63:0] i_block,
    input  wire logic [63:0] i_key,
    output logic             o_done,
    output logic [63:0]      o_result
);
    logic [31:0] r_l, r_r;
    logic [55:0] r_cd;
    logic [3:0]  r_round;
    logic        r_busy, r_dec, r_done;

    logic [27:0] c_cur, d_cur;
    logic [55:0] cd_use, cd_next;
    logic        rot2_enc, rot2_dec;
    logic [31:0] f_out;
    logic [63:0] ip_out;

    assign c_cur    = r_cd[55:28];
    assign d_cur    = r_cd[27:0];
    assign rot2_enc = C_ROT2[r_round];
    assign rot2_dec = C_ROT2[4'd15 - r_round];

    // Key schedule: rotate left before use when enciphering,
    // use then rotate right when deciphering
    always_comb begin
        if (r_dec) begin
            cd_use  = r_cd;
            cd_next = rot2_dec ? {c_cur[1:0], c_cur[27:2], d_cur[1:0], d_cur[27:2]}
                               : {c_cur[0], c_cur[27:1], d_cur[0], d_cur[27:1]};
        end else begin
            cd_use  = rot2_enc ? {c_cur[25:0], c_cur[27:26], d_cur[25:0], d_cur[27:26]}
                               : {c_cur[26:0], c_cur[27], d_cur[26:0], d_cur[27]};
            cd_next = cd_use;
        end
    end

    // Round function
    assign f_out  = perm_p(sbox_all(perm_e(r_r) ^ perm_pc2(cd_use)));
    assign ip_out = perm_ip(i_block);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 4'd1;
                if (r_round == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load the block and key, then advance one round a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_l   <= ip_out[63:32];
            r_r   <= ip_out[31:0];
            r_cd  <= perm_pc1(i_key);
            r_dec <= i_ctl.dec;
        end else if (r_busy) begin
            r_l  <= r_r;
            r_r  <= r_l ^ f_out;
            r_cd <= cd_next;
        end
    end

    assign o_done   = r_done;
    assign o_result = perm_fp({r_r, r_l});
endmodule
`default_nettype wire

/* design/dcm_ctrl.sv */
// Sequencer: mode decode, CBC chaining and pass scheduling of the DES unit.
`timescale 1ns / 1ps
`default_nettype none
module dcm_ctrl
    import dcm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    dcm_in_if.sink     i_in,
    dcm_out_if.source  o_out,
    output t_des_ctl   o_des_ctl,
    output logic [63:0] o_des_block,
    output logic [63:0] o_des_key,
    input  wire logic  i_des_done,
    input  wire logic [63:0] i_des_result
);
    t_state      r_state, n_state;
    logic [1:0]  r_pass;
    logic        r_multi, r_last;
    logic [63:0] r_blk, r_chain, r_key_a, r_key_b, r_key_c, r_mac;
    logic        r_err;

    logic [2:0]  mode_eff;
    logic        bad, accept, multi, pass_more;
    logic [63:0] mask, k2, k3;

    // Decode the mode and check the key configuration
    always_comb begin
        if (i_cfg.mac_mode == MODE_AUTO) begin
            case (i_cfg.key_length)
                KLEN_8:  mode_eff = MODE_X99;
                KLEN_16: mode_eff = MODE_ISO_ALG3;
                default: mode_eff = MODE_ISO16609;
            endcase
        end else begin
            mode_eff = i_cfg.mac_mode;
        end
        bad = (i_cfg.key_length > KLEN_24) || (i_cfg.mac_mode > MODE_AUTO)
            || ((mode_eff == MODE_X99) && (i_cfg.key_length != KLEN_8));
        k2 = (i_cfg.key_length == KLEN_8)  ? i_cfg.key_first : i_cfg.key_second;
        k3 = (i_cfg.key_length == KLEN_24) ? i_cfg.key_third : i_cfg.key_first;
        multi = (mode_eff == MODE_ISO16609)
             || (i_in.last_block && ((mode_eff == MODE_X919) || (mode_eff == MODE_ISO_ALG3)));
    end

    // Keep the leading bytes the count covers
    always_comb begin
        for (int b = 0; b < 8; b++) mask[63-8*b -: 8] = {8{4'(b) < i_in.byte_count}};
    end

    assign accept    = i_in.valid && i_in.ready;
    assign pass_more = r_multi && (r_pass != 2'd2);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) begin
                if (bad) n_state = i_in.last_block ? S_OUT : S_IDLE;
                else     n_state = S_LOAD;
            end
            S_LOAD: n_state = S_RUN;
            S_RUN: if (i_des_done) begin
                if (pass_more)   n_state = S_LOAD;
                else if (r_last) n_state = S_OUT;
                else             n_state = S_IDLE;
            end
            S_OUT: if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_in.ready      = (r_state == S_IDLE);
        o_out.valid     = (r_state == S_OUT);
        o_des_ctl.start = (r_state == S_LOAD);
        o_des_ctl.dec   = (r_pass == 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Chain value, pass count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
            r_pass  <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (accept) begin
                    r_pass  <= '0;
                    r_multi <= multi;
                    r_last  <= i_in.last_block;
                    r_blk   <= r_chain ^ (i_in.data_block & mask);
                    r_key_a <= i_cfg.key_first;
                    r_key_b <= k2;
                    r_key_c <= (mode_eff == MODE_ISO16609) ? i_cfg.key_first : k3;
                    r_mac   <= '0;
                    r_err   <= bad;
                    if (bad && i_in.last_block) r_chain <= '0;
                end
                S_RUN: if (i_des_done) begin
                    if (pass_more) begin
                        r_blk  <= i_des_result;
                        r_pass <= r_pass + 2'd1;
                    end else if (r_last) begin
                        r_mac   <= i_des_result;
                        r_chain <= '0;
                    end else begin
                        r_chain <= i_des_result;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_pass)
            2'd0:    o_des_key = r_key_a;
            2'd1:    o_des_key = r_key_b;
            default: o_des_key = r_key_c;
        endcase
    end

    assign o_des_block     = r_blk;
    assign o_out.mac_value = r_mac;
    assign o_out.key_error = r_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.key_error |-> o_out.mac_value == 64'd0)
        else $error("error result with nonzero MAC");
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_des_done |-> r_state == S_RUN)
        else $error("DES completion outside run state");
    a_load_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> r_state == S_RUN)
        else $error("load not followed by run");
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && !r_multi |-> r_pass == 2'd0)
        else $error("extra pass on single-DES item");
endmodule
`default_nettype wire

/* design/des_cbc_mac_engine.sv */
// Top level: DES CBC-MAC engine with configuration port.
`timescale 1ns / 1ps
`default_nettype none
// Computes a DES retail-family CBC-MAC (X9.9, ISO 9797-1 alg 3, X9.19,
// ISO 16609 or auto by key length) over 8-byte blocks, one result per last
// block. A single DES round unit is shared by all passes; each DES pass
// is a load step, 16 rounds and a completion step, so a block occupies
// the engine for one pass under single DES and for three passes when
// three passes are needed. The input is not ready while a block is in work or
// while a result waits to be taken. A bad key setting drops non-final blocks
// at once and answers a final block with a zero MAC and key_error set.
module des_cbc_mac_engine
    import dcm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [63:0]       i_pwdata,
    output logic [63:0]            o_prdata,
    output logic                   o_pready,
    dcm_in_if.sink                 i_in,
    dcm_out_if.source              o_out
);
    t_cfg        cfg;
    t_des_ctl    des_ctl;
    logic [63:0] des_block, des_key, des_result;
    logic        des_done;

    dcm_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_psel, .i_penable, .i_pwrite, .i_paddr, .i_pwdata,
        .o_prdata, .o_pready, .o_cfg(cfg)
    );

    dcm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_in, .o_out,
        .o_des_ctl(des_ctl), .o_des_block(des_block), .o_des_key(des_key),
        .i_des_done(des_done), .i_des_result(des_result)
    );

    dcm_des_unit u_des (
        .i_clk, .i_rst_n, .i_ctl(des_ctl), .i_block(des_block), .i_key(des_key),
        .o_done(des_done), .o_result(des_result)
    );
endmodule
`default_nettype wire
